[rtl/vsw_avg_pkg.sv]
// Package for the vital-sign window averager: window size, derived widths,
// register indexes and reset values, status codes. No dependencies.
`default_nettype none
package vsw_avg_pkg;
    localparam int WINDOW_LEN = 10;

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int SUM_W  = $clog2(WINDOW_LEN * 255 + 1);
    localparam int PDIV_W = $clog2(255 * (WINDOW_LEN - 1) + 1);
    localparam int DIV_W  = (PDIV_W > 11) ? PDIV_W : 11;
    localparam int NUM_W  = $clog2(WINDOW_LEN * 25500 + 1);
    localparam int REM_W  = (NUM_W > DIV_W + 8) ? NUM_W : DIV_W + 8;
    localparam int Q_W    = 9;
    localparam int STEP_W = $clog2(Q_W + 1);
    localparam int ADDR_W = 3;

    localparam logic REG_PARTIAL_SCALE = 1'b0;
    localparam logic REG_FULL_DIVISOR  = 1'b1;

    localparam logic [7:0]  SCALE_RST = 8'd103;
    localparam logic [10:0] FULL_RST  = 11'd1045;

    localparam logic [7:0] STATUS_NC      = 8'd0;
    localparam logic [7:0] STATUS_TIMEOUT = 8'd255;
endpackage
`default_nettype wire

[rtl/vital_sign_window_averager.sv]
// The input is ready only in the idle state, so a new item is not accepted until the
// last one has gone through the load state, the 9-step bit-serial divider and the done state
// (one quotient bit per cycle, three channel lanes sharing one divisor).
// The next item is accepted while a finished result waits in the output register.
// Reset (synchronous, active low) empties the window, clears the write index
// and full flag, and loads partial_scale = 103 and full_divisor = 1045.
// Depends on vsw_avg_pkg.
`default_nettype none
module vital_sign_window_averager
    import vsw_avg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [23:0]       i_s_axis_tdata,  // systolic_or_status, diastolic, pulse
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,  // avg_systolic, avg_diastolic,
                                                    // avg_pulse, sample_index, zero pad
    output logic                   o_m_axis_tuser,  // connected
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_CALC, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_m_valid, n_m_valid;
    logic [31:0]         r_m_data, n_m_data;
    logic                r_m_user, n_m_user;

    logic [7:0]          r_scale;
    logic [10:0]         r_full_div;

    logic [23:0]         r_win [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] r_vld;
    logic [IDX_W-1:0]    r_wr_idx;
    logic                r_full;
    logic [SUM_W-1:0]    r_sum [3];
    logic                r_conn;

    logic [REM_W-1:0]    r_rem [3];
    logic [Q_W-1:0]      r_q [3];
    logic [2:0]          r_nz;
    logic [REM_W-1:0]    r_dsh;

    logic                w_acc;
    logic                w_status;
    logic [23:0]         w_old;
    logic [7:0]          w_in_b [3];
    logic [7:0]          w_old_b [3];
    logic [8+IDX_W-1:0]  w_pprod;
    logic [DIV_W-1:0]    w_div;
    logic [7:0]          w_avg [3];
    logic                w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_FULL_DIVISOR) ? {21'd0, r_full_div} : {24'd0, r_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_RST;
            r_full_div <= FULL_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_PARTIAL_SCALE) begin
                r_scale <= pwdata[7:0];
            end else begin
                r_full_div <= pwdata[10:0];
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_status = (i_s_axis_tdata[7:0] == STATUS_NC) ||
                      (i_s_axis_tdata[7:0] == STATUS_TIMEOUT);
    assign w_old    = r_vld[r_wr_idx] ? r_win[r_wr_idx] : 24'd0;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_in_b[c]  = i_s_axis_tdata[8*c +: 8];
            w_old_b[c] = w_old[8*c +: 8];
        end
    end

    // window store and running sums
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_status) begin
            r_win[r_wr_idx] <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wr_idx <= '0;
            r_full   <= 1'b0;
            r_conn   <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else if (w_acc) begin
            if (w_status) begin
                r_vld    <= '0;
                r_wr_idx <= '0;
                r_full   <= 1'b0;
                r_conn   <= 1'b0;
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= '0;
                end
            end else begin
                r_vld[r_wr_idx] <= 1'b1;
                r_conn          <= 1'b1;
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(w_in_b[c]) - SUM_W'(w_old_b[c]);
                end
                if (r_wr_idx == IDX_W'(WINDOW_LEN - 1)) begin
                    r_wr_idx <= '0;
                    r_full   <= 1'b1;
                end else begin
                    r_wr_idx <= r_wr_idx + 1'b1;
                end
            end
        end
    end

    // divisor and bit-serial restoring division, one quotient bit per cycle
    assign w_pprod = (8+IDX_W)'(r_scale) * (8+IDX_W)'(r_wr_idx);
    assign w_div   = r_full ? DIV_W'(r_full_div) : DIV_W'(w_pprod);

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_dsh <= REM_W'({w_div, 8'h00});
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= (REM_W'(r_sum[c]) << 6) + (REM_W'(r_sum[c]) << 5) +
                            (REM_W'(r_sum[c]) << 2);
                r_q[c]   <= '0;
                r_nz[c]  <= (r_sum[c] != '0);
            end
        end else if (r_state == S_CALC) begin
            r_dsh <= r_dsh >> 1;
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= r_dsh) begin
                    r_rem[c] <= r_rem[c] - r_dsh;
                    r_q[c]   <= {r_q[c][Q_W-2:0], 1'b1};
                end else begin
                    r_q[c]   <= {r_q[c][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!r_nz[c]) begin
                w_avg[c] = 8'd0;
            end else if (r_q[c][Q_W-1]) begin
                w_avg[c] = 8'hFF;
            end else begin
                w_avg[c] = r_q[c][7:0];
            end
        end
        if (w_avg[2] == 8'd0) begin
            w_avg[0] = 8'd0;
            w_avg[1] = 8'd0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_CALC;
                n_step  = '0;
            end
            S_CALC: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(Q_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'd0, 4'(r_wr_idx), w_avg[2], w_avg[1], w_avg[0]};
                    n_m_user  = r_conn;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_m_valid <= n_m_valid;
        end
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx <= IDX_W'(WINDOW_LEN - 1))
        else $error("write index out of range");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum[0] <= SUM_W'(WINDOW_LEN * 255)) && (r_sum[2] <= SUM_W'(WINDOW_LEN * 255)))
        else $error("running sum exceeds window bound");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status) |=> (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0
                                 && !r_full && r_vld == '0))
        else $error("status item did not empty the window");

    a_disc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[27:0] == 28'd0))
        else $error("disconnected result carries nonzero data");

    a_pulse_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[23:16] == 8'd0) |->
        (o_m_axis_tdata[15:0] == 16'd0))
        else $error("zero pulse average with nonzero pressure averages");
endmodule
`default_nettype wire
